// ===== hdl/josephus_elimination_order_assert.svh =====
// ----------------------------------------------------------------------------
// Josephus elimination order assertion macros
// Shared assertion forms for the elimination order block.
// ----------------------------------------------------------------------------
`ifndef JOSEPHUS_ELIMINATION_ORDER_ASSERT_SVH
`define JOSEPHUS_ELIMINATION_ORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JEO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: consequent does not hold in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define JEO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent does not hold in the next cycle");

`endif

// ===== hdl/jeo_pkg.sv =====
// ----------------------------------------------------------------------------
// Josephus elimination order package
// Widths, request and result types, and the control store of the sequencer.
// ----------------------------------------------------------------------------
package jeo_pkg;

    localparam int MAX_GROUP = 64;
    localparam int PTR_W     = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int LABEL_W   = 7;
    localparam int SKIP_W    = 16;
    localparam int BIT_W     = $clog2(SKIP_W);
    localparam int STEP_W    = 3;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE     = t_step'(0);
    localparam t_step ST_DIV_INIT = t_step'(1);
    localparam t_step ST_DIV_STEP = t_step'(2);
    localparam t_step ST_SCAN     = t_step'(3);
    localparam t_step ST_CHECK    = t_step'(4);
    localparam t_step ST_LOOP     = t_step'(5);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SCAN
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IDLE_STAY,
        C_DIV_MORE,
        C_SCAN_MORE,
        C_JOB_DONE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
        logic  busy;
    } t_uword;

    typedef struct packed {
        logic [LABEL_W-1:0] group_size;
        logic [SKIP_W-1:0]  skip_count;
    } t_req;

    typedef struct packed {
        logic [LABEL_W-1:0] eliminated_label;
        logic               is_last;
    } t_res;

    function automatic t_uword ucode(input t_step addr);
        t_uword w;
        case (addr)
            ST_IDLE:     w = '{op: OP_LOAD,     cond: C_IDLE_STAY, target: ST_IDLE,     busy: 1'b0};
            ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_ALWAYS,    target: ST_DIV_STEP, busy: 1'b1};
            ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: ST_DIV_STEP, busy: 1'b1};
            ST_SCAN:     w = '{op: OP_SCAN,     cond: C_SCAN_MORE, target: ST_SCAN,     busy: 1'b1};
            ST_CHECK:    w = '{op: OP_NOP,      cond: C_JOB_DONE,  target: ST_IDLE,     busy: 1'b1};
            ST_LOOP:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: ST_DIV_INIT, busy: 1'b1};
            default:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: ST_IDLE,     busy: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/josephus_elimination_order.sv =====
// Each request yields one result per member, n results for a group of n up to
// 64 (larger groups are clamped to 64). Every removal runs the bit-serial
// remainder unit, a scan visiting one circle position per cycle (at most n),
// then the check and loop control steps; busy stays high for the whole job.
// Results leave on a one-cycle strobe and the receiver cannot stall them.
// Synchronous reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
// Josephus elimination order
// Microcoded sequencer that emits the removal order of a Josephus circle.
// ----------------------------------------------------------------------------
`include "josephus_elimination_order_assert.svh"

module josephus_elimination_order
    import jeo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    t_step                r_step, n_step;
    logic [MAX_GROUP-1:0] r_alive, n_alive;
    logic [PTR_W-1:0]     r_ptr, n_ptr;
    logic [PTR_W-1:0]     r_n_m1, n_n_m1;
    logic [CNT_W-1:0]     r_remaining, n_remaining;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [SKIP_W-1:0]    r_kd, n_kd;
    logic [SKIP_W-1:0]    r_quo, n_quo;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_strobe, n_strobe;
    t_res                 r_res, n_res;

    t_uword               w_uw;
    logic [CNT_W-1:0]     w_n_eff;
    logic [MAX_GROUP-1:0] w_mask;
    logic [CNT_W:0]       w_trial;
    logic                 w_ge;
    logic                 w_alive_here;
    logic                 w_hit;
    logic [PTR_W-1:0]     w_ptr_next;
    logic                 w_cond;

    always_comb begin
        w_uw = ucode(r_step);
        w_n_eff = (i_req.group_size > LABEL_W'(MAX_GROUP)) ? CNT_W'(MAX_GROUP)
                                                           : CNT_W'(i_req.group_size);
        for (int i = 0; i < MAX_GROUP; i++) begin
            w_mask[i] = CNT_W'(i) < w_n_eff;
        end
        w_trial      = {r_rem, r_quo[SKIP_W-1]};
        w_ge         = w_trial >= {1'b0, r_remaining};
        w_alive_here = r_alive[r_ptr];
        w_hit        = w_alive_here && (r_rem == '0);
        w_ptr_next   = (r_ptr == r_n_m1) ? '0 : r_ptr + PTR_W'(1);

        case (w_uw.cond)
            C_ALWAYS:    w_cond = 1'b1;
            C_IDLE_STAY: w_cond = !start || (w_n_eff == '0);
            C_DIV_MORE:  w_cond = r_bit != '0;
            C_SCAN_MORE: w_cond = !w_hit;
            C_JOB_DONE:  w_cond = r_remaining == '0;
            default:     w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_uw.target : r_step + t_step'(1);

        n_alive     = r_alive;
        n_ptr       = r_ptr;
        n_n_m1      = r_n_m1;
        n_remaining = r_remaining;
        n_rem       = r_rem;
        n_kd        = r_kd;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_strobe    = 1'b0;
        n_res       = r_res;

        case (w_uw.op)
            OP_LOAD: begin
                if (start) begin
                    n_alive     = w_mask;
                    n_ptr       = '0;
                    n_n_m1      = PTR_W'(w_n_eff - CNT_W'(1));
                    n_remaining = w_n_eff;
                    n_kd        = (i_req.skip_count == '0) ? '0
                                                           : i_req.skip_count - SKIP_W'(1);
                end
            end
            OP_DIV_INIT: begin
                n_rem = '0;
                n_quo = r_kd;
                n_bit = BIT_W'(SKIP_W - 1);
            end
            OP_DIV_STEP: begin
                n_rem = w_ge ? CNT_W'(w_trial - {1'b0, r_remaining}) : CNT_W'(w_trial);
                n_quo = {r_quo[SKIP_W-2:0], 1'b0};
                n_bit = r_bit - BIT_W'(1);
            end
            OP_SCAN: begin
                n_ptr = w_ptr_next;
                if (w_hit) begin
                    n_alive[r_ptr]         = 1'b0;
                    n_remaining            = r_remaining - CNT_W'(1);
                    n_strobe               = 1'b1;
                    n_res.eliminated_label = LABEL_W'(r_ptr) + LABEL_W'(1);
                    n_res.is_last          = r_remaining == CNT_W'(1);
                end else if (w_alive_here) begin
                    n_rem = r_rem - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_alive     <= '0;
            r_ptr       <= '0;
            r_n_m1      <= '0;
            r_remaining <= '0;
            r_rem       <= '0;
            r_bit       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_alive     <= n_alive;
            r_ptr       <= n_ptr;
            r_n_m1      <= n_n_m1;
            r_remaining <= n_remaining;
            r_rem       <= n_rem;
            r_bit       <= n_bit;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd  <= n_kd;
        r_quo <= n_quo;
        r_res <= n_res;
    end

    assign busy     = w_uw.busy;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    `JEO_ASSERT_NEXT(a_hit_emits, i_clk, i_rst_n, (r_step == ST_SCAN) && w_hit, r_strobe)
    `JEO_ASSERT_SAME(a_last_empties, i_clk, i_rst_n, r_strobe && r_res.is_last, r_remaining == '0)
    `JEO_ASSERT_SAME(a_ptr_in_circle, i_clk, i_rst_n, busy, r_ptr <= r_n_m1)
    `JEO_ASSERT_SAME(a_offset_bound, i_clk, i_rst_n, r_step == ST_SCAN, r_rem < r_remaining)

endmodule
